FILE: hw/rtl/e2q_pkg.sv
package e2q_pkg;

	localparam int ANGLE_W = 20;
	localparam int CW = 34;
	localparam int ZW = 34;
	localparam int ATAN_LEN = 24;
	localparam int QW = 16;
	localparam int CORDIC_STEPS = 16;

	localparam logic signed [ZW-1:0] PI_UNITS = 34'sd3373259426;
	localparam logic signed [ZW-1:0] HALF_PI_UNITS = 34'sd1686629713;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] roll_angle;
		logic signed [ANGLE_W-1:0] pitch_angle;
		logic signed [ANGLE_W-1:0] yaw_angle;
	} angles_t;

	typedef struct packed {
		logic signed [QW-1:0] quat_w;
		logic signed [QW-1:0] quat_x;
		logic signed [QW-1:0] quat_y;
		logic signed [QW-1:0] quat_z;
	} quat_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic neg;
	} rot_t;

	function automatic logic signed [ZW-1:0] atan_units(input int i);
		logic signed [ZW-1:0] r;
		unique case (i)
			0: r = 34'sh3243F6A8;
			1: r = 34'sh1DAC6705;
			2: r = 34'sh0FADBAFC;
			3: r = 34'sh07F56EA6;
			4: r = 34'sh03FEAB76;
			5: r = 34'sh01FFD55B;
			6: r = 34'sh00FFFAAA;
			7: r = 34'sh007FFF55;
			8: r = 34'sh003FFFEA;
			9: r = 34'sh001FFFFD;
			10: r = 34'sh000FFFFF;
			11: r = 34'sh0007FFFF;
			12: r = 34'sh0003FFFF;
			13: r = 34'sh0001FFFF;
			14: r = 34'sh0000FFFF;
			15: r = 34'sh00007FFF;
			16: r = 34'sh00003FFF;
			17: r = 34'sh00001FFF;
			18: r = 34'sh00000FFF;
			19: r = 34'sh000007FF;
			20: r = 34'sh000003FF;
			21: r = 34'sh000001FF;
			22: r = 34'sh000000FF;
			default: r = 34'sh0000007F;
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/euler_to_quaternion.sv
// Euler ZYX to quaternion converter.
// Input channel in_valid/in_ready carries roll, pitch and yaw angles (signed
// Q3.16 radians) as one struct in in_data; output channel out_valid/out_ready
// carries quat_w/x/y/z in signed Q1.15, saturated, as one struct in out_data.
// One transaction per cycle is accepted while the output can move.
// The pipeline has one stage for quadrant reduction, one CORDIC cell per step
// (steps capped at 24), then four combine stages and the output register.
// Throughput is one transaction per clock while the output can move.
// When out_ready is low the output register holds; valid stages behind it
// advance into empty ones, so a bubble in the pipe is squeezed out and
// in_ready drops only when every stage holds a transaction.
// Reset clears all valid flags; data registers are not reset.
module euler_to_quaternion #(
	parameter int CORDIC_STEPS = e2q_pkg::CORDIC_STEPS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  e2q_pkg::angles_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output e2q_pkg::quat_t   out_data
);
	localparam int OUT_WIDTH = e2q_pkg::QW;
	localparam int N = (CORDIC_STEPS > e2q_pkg::ATAN_LEN) ? e2q_pkg::ATAN_LEN : CORDIC_STEPS;
	localparam int D = N + 6;

	logic [D-1:0] vld_q;
	logic [D-1:0] adv;
	e2q_pkg::rot_t red_s0 [3];
	e2q_pkg::rot_t st [N+1][3];
	logic signed [33:0] cs [6];
	logic signed [OUT_WIDTH-1:0] q [4];
	logic signed [OUT_WIDTH-1:0] out_q [4];
	logic signed [e2q_pkg::ANGLE_W-1:0] ang [3];

	always_comb begin
		adv[D-1] = !vld_q[D-1] || out_ready;
		for (int k = D - 2; k >= 0; k--) adv[k] = !vld_q[k] || adv[k+1];
	end
	assign in_ready = adv[0];

	assign ang[0] = in_data.roll_angle;
	assign ang[1] = in_data.pitch_angle;
	assign ang[2] = in_data.yaw_angle;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			for (int k = 0; k < 3; k++) begin
				logic signed [33:0] z;
				z = 34'(ang[k]) <<< 13;
				red_s0[k].x <= e2q_pkg::CORDIC_GAIN;
				red_s0[k].y <= '0;
				if (z > e2q_pkg::HALF_PI_UNITS) begin
					red_s0[k].z <= z - e2q_pkg::PI_UNITS; red_s0[k].neg <= 1'b1;
				end else if (z < -e2q_pkg::HALF_PI_UNITS) begin
					red_s0[k].z <= z + e2q_pkg::PI_UNITS; red_s0[k].neg <= 1'b1;
				end else begin
					red_s0[k].z <= z; red_s0[k].neg <= 1'b0;
				end
			end
		end
	end

	assign st[0] = red_s0;

	for (genvar g = 0; g < N; g++) begin : g_cell
		e2q_cell #(.STEP(g)) u_cell (
			.clk(clk), .en(adv[g+1]), .din(st[g]), .dout(st[g+1])
		);
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cs[2*k]   = st[N][k].neg ? -st[N][k].x : st[N][k].x;
			cs[2*k+1] = st[N][k].neg ? -st[N][k].y : st[N][k].y;
		end
	end

	e2q_combine #(.OUT_WIDTH(OUT_WIDTH)) u_comb (
		.clk(clk), .en(adv[N+4:N+1]),
		.cr(cs[0]), .sr(cs[1]), .cp(cs[2]), .sp(cs[3]), .cy(cs[4]), .sy(cs[5]),
		.q(q)
	);

	always_ff @(posedge clk) begin
		if (adv[D-1]) out_q <= q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < D; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign out_valid = vld_q[D-1];
	assign out_data.quat_w = out_q[0];
	assign out_data.quat_x = out_q[1];
	assign out_data.quat_y = out_q[2];
	assign out_data.quat_z = out_q[3];

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (&vld_q) && !out_ready)
		else $error("input blocked with a bubble in the pipe");
endmodule

FILE: hw/rtl/e2q_cell.sv
module e2q_cell #(
	parameter int STEP = 0
) (
	input  logic           clk,
	input  logic           en,
	input  e2q_pkg::rot_t  din [3],
	output e2q_pkg::rot_t  dout [3]
);
	e2q_pkg::rot_t nxt [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			nxt[k].neg = din[k].neg;
			if (!din[k].z[e2q_pkg::ZW-1]) begin
				nxt[k].x = din[k].x - (din[k].y >>> STEP);
				nxt[k].y = din[k].y + (din[k].x >>> STEP);
				nxt[k].z = din[k].z - e2q_pkg::atan_units(STEP);
			end else begin
				nxt[k].x = din[k].x + (din[k].y >>> STEP);
				nxt[k].y = din[k].y - (din[k].x >>> STEP);
				nxt[k].z = din[k].z + e2q_pkg::atan_units(STEP);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end
endmodule

FILE: hw/rtl/e2q_combine.sv
module e2q_combine #(
	parameter int OUT_WIDTH = e2q_pkg::QW
) (
	input  logic                        clk,
	input  logic [3:0]                  en,
	input  logic signed [33:0]          cr, sr, cp, sp, cy, sy,
	output logic signed [OUT_WIDTH-1:0] q [4]
);
	localparam int SH = 61 - OUT_WIDTH;
	logic signed [33:0] a_s1 [8];
	logic signed [33:0] c_s1 [8];
	logic signed [67:0] p_s2 [8];
	logic signed [33:0] c_s2 [8];
	logic signed [67:0] t_s3 [8];
	logic signed [68:0] s_s4 [4];
	logic signed [33:0] ab [8];
	logic signed [68:0] sum [4];
	logic signed [68:0] rnd [4];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			a_s1[0] <= cr; a_s1[1] <= sr; a_s1[2] <= sr; a_s1[3] <= cr;
			a_s1[4] <= cr; a_s1[5] <= sr; a_s1[6] <= cr; a_s1[7] <= sr;
			c_s1[0] <= cp; c_s1[1] <= sp; c_s1[2] <= cp; c_s1[3] <= sp;
			c_s1[4] <= sp; c_s1[5] <= cp; c_s1[6] <= cp; c_s1[7] <= sp;
			c_s2[0] <= cy; c_s2[1] <= sy; c_s2[2] <= cy; c_s2[3] <= sy;
			c_s2[4] <= cy; c_s2[5] <= sy; c_s2[6] <= sy; c_s2[7] <= cy;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int k = 0; k < 8; k++) p_s2[k] <= a_s1[k] * c_s1[k];
		end
	end

	logic signed [33:0] c_d [8];
	always_ff @(posedge clk) begin
		if (en[1]) c_d <= c_s2;
	end

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			ab[k] = 34'((p_s2[k] + 68'sd536870912) >>> 30);
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int k = 0; k < 8; k++) t_s3[k] <= ab[k] * c_d[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			s_s4[0] <= 69'(t_s3[0]) + 69'(t_s3[1]);
			s_s4[1] <= 69'(t_s3[2]) - 69'(t_s3[3]);
			s_s4[2] <= 69'(t_s3[4]) + 69'(t_s3[5]);
			s_s4[3] <= 69'(t_s3[6]) - 69'(t_s3[7]);
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			sum[k] = s_s4[k] + (69'sd1 <<< (SH - 1));
			rnd[k] = sum[k] >>> SH;
			if (rnd[k] > 69'sd2 ** (OUT_WIDTH - 1) - 1)
				q[k] = {1'b0, {(OUT_WIDTH-1){1'b1}}};
			else if (rnd[k] < -(69'sd2 ** (OUT_WIDTH - 1)))
				q[k] = {1'b1, {(OUT_WIDTH-1){1'b0}}};
			else
				q[k] = rnd[k][OUT_WIDTH-1:0];
		end
	end
endmodule
